// ===== rtl/sard_pkg.sv =====
// sard_pkg: shared constants and types for the sort-and-report-duplicates unit
// no dependencies

package sard_pkg;

  // default store depth and result limit per set
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned MAX_RESULTS  = 32;
  localparam int unsigned VAL_W        = 32;

  // outcome of the shared compare unit
  typedef struct packed {
    logic gt;  // a > b, signed
    logic eq;  // a == b
  } cmp_res_t;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_KEY   = 6'b000100,
    S_CMP   = 6'b001000,
    S_SCAN  = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

endpackage

// ===== rtl/sard_store.sv =====
// sard_store: value store, one write port and one registered read port
// depends on sard_pkg

module sard_store #(
  parameter int unsigned DEPTH = sard_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic signed [sard_pkg::VAL_W-1:0] wdata_i,
  input  logic                              re_i,
  input  logic [AW-1:0]                     raddr_i,
  output logic signed [sard_pkg::VAL_W-1:0] rdata_o
);

  logic signed [sard_pkg::VAL_W-1:0] mem [DEPTH];
  logic signed [sard_pkg::VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sard_cmp.sv =====
// sard_cmp: shared signed comparator used by both the sort and the scan
// depends on sard_pkg

module sard_cmp (
  input  logic signed [sard_pkg::VAL_W-1:0] a_i,
  input  logic signed [sard_pkg::VAL_W-1:0] b_i,
  output sard_pkg::cmp_res_t                res_o
);

  always_comb begin
    res_o.gt = (a_i > b_i);
    res_o.eq = (a_i == b_i);
  end

endmodule

// ===== rtl/sard_ctrl.sv =====
// sard_ctrl: sequencer for load, insertion sort, duplicate scan and result output
// depends on sard_pkg; drives sard_store and reads sard_cmp

module sard_ctrl #(
  parameter int unsigned CAPACITY = sard_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = $clog2(CAPACITY)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [sard_pkg::VAL_W-1:0] value_i,
  input  logic                              last_i,
  // store port
  output logic                              we_o,
  output logic [AW-1:0]                     waddr_o,
  output logic signed [sard_pkg::VAL_W-1:0] wdata_o,
  output logic                              re_o,
  output logic [AW-1:0]                     raddr_o,
  input  logic signed [sard_pkg::VAL_W-1:0] rdata_i,
  // compare unit
  output logic signed [sard_pkg::VAL_W-1:0] cmp_b_o,
  input  sard_pkg::cmp_res_t                cmp_i,
  // results
  output logic                              result_valid_o,
  output logic signed [sard_pkg::VAL_W-1:0] dup_value_o,
  output logic                              none_found_o,
  output logic                              overflow_o,
  output logic                              end_of_run_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned RW = $clog2(sard_pkg::MAX_RESULTS + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [RW-1:0] MaxC = RW'(sard_pkg::MAX_RESULTS);

  sard_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] a_q, a_d;
  logic          rv_q, rv_d;
  logic          first_q, first_d;
  logic          seen_q, seen_d;
  logic          pend_v_q, pend_v_d;
  logic [RW-1:0] found_q, found_d;
  logic signed [sard_pkg::VAL_W-1:0] key_q, key_d;
  logic signed [sard_pkg::VAL_W-1:0] prev_q, prev_d;
  logic signed [sard_pkg::VAL_W-1:0] pend_q, pend_d;

  logic                              res_v_q, res_v_d;
  logic signed [sard_pkg::VAL_W-1:0] res_val_q, res_val_d;
  logic                              res_none_q, res_none_d;
  logic                              res_ovf_q, res_ovf_d;
  logic                              res_eor_q, res_eor_d;

  logic [CW-1:0] i_inc;
  logic [CW-1:0] i_dec;
  logic [CW-1:0] j_dec;
  logic [CW-1:0] j_dec2;

  assign i_inc  = i_q + CW'(1);
  assign i_dec  = i_q - CW'(1);
  assign j_dec  = j_q - CW'(1);
  assign j_dec2 = j_q - CW'(2);

  assign busy_o = (state_q != sard_pkg::S_IDLE);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    j_d        = j_q;
    a_d        = a_q;
    rv_d       = 1'b0;
    first_d    = first_q;
    seen_d     = seen_q;
    pend_v_d   = pend_v_q;
    found_d    = found_q;
    key_d      = key_q;
    prev_d     = prev_q;
    pend_d     = pend_q;
    res_v_d    = 1'b0;
    res_val_d  = res_val_q;
    res_none_d = res_none_q;
    res_ovf_d  = res_ovf_q;
    res_eor_d  = res_eor_q;
    we_o       = 1'b0;
    waddr_o    = count_q[AW-1:0];
    wdata_o    = value_i;
    re_o       = 1'b0;
    raddr_o    = i_q[AW-1:0];
    cmp_b_o    = (state_q == sard_pkg::S_CMP) ? key_q : prev_q;

    unique case (state_q)
      sard_pkg::S_IDLE: begin
        if (start_i) begin
          if (count_q < CapC) begin
            we_o    = 1'b1;
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            i_d = CW'(1);
            if (count_d >= CW'(2)) begin
              state_d = sard_pkg::S_ISSUE;
            end else begin
              state_d = sard_pkg::S_SCAN;
            end
            // scan bookkeeping, harmless when sorting first
            a_d      = '0;
            first_d  = 1'b1;
            seen_d   = 1'b0;
            pend_v_d = 1'b0;
            found_d  = '0;
          end
        end
      end

      sard_pkg::S_ISSUE: begin
        re_o    = 1'b1;
        raddr_o = i_q[AW-1:0];
        state_d = sard_pkg::S_KEY;
      end

      sard_pkg::S_KEY: begin
        key_d   = rdata_i;
        j_d     = i_q;
        re_o    = 1'b1;
        raddr_o = i_dec[AW-1:0];
        state_d = sard_pkg::S_CMP;
      end

      sard_pkg::S_CMP: begin
        // rdata holds store[j-1]
        we_o    = 1'b1;
        waddr_o = j_q[AW-1:0];
        if ((j_q != '0) && cmp_i.gt) begin
          wdata_o = rdata_i;
          j_d     = j_dec;
          re_o    = 1'b1;
          raddr_o = j_dec2[AW-1:0];
        end else begin
          wdata_o = key_q;
          i_d     = i_inc;
          if (i_inc < count_q) begin
            re_o    = 1'b1;
            raddr_o = i_inc[AW-1:0];
            state_d = sard_pkg::S_KEY;
          end else begin
            state_d = sard_pkg::S_SCAN;
          end
        end
      end

      sard_pkg::S_SCAN: begin
        if (a_q != count_q) begin
          re_o    = 1'b1;
          raddr_o = a_q[AW-1:0];
          a_d     = a_q + CW'(1);
          rv_d    = 1'b1;
        end
        if (rv_q) begin
          if (first_q) begin
            first_d = 1'b0;
            prev_d  = rdata_i;
          end else if (cmp_i.eq) begin
            if (!seen_q) begin
              // new duplicated value, release the one held back
              seen_d   = 1'b1;
              res_v_d  = pend_v_q;
              res_val_d  = pend_q;
              res_none_d = 1'b0;
              res_ovf_d  = ovf_q;
              res_eor_d  = 1'b0;
              pend_d   = rdata_i;
              pend_v_d = 1'b1;
              found_d  = found_q + RW'(1);
              if (found_d == MaxC) begin
                state_d = sard_pkg::S_FIN;
              end
            end
          end else begin
            seen_d = 1'b0;
            prev_d = rdata_i;
          end
        end
        if ((a_q == count_q) && !rv_q) begin
          state_d = sard_pkg::S_FIN;
        end
      end

      sard_pkg::S_FIN: begin
        res_v_d    = 1'b1;
        res_val_d  = pend_v_q ? pend_q : '0;
        res_none_d = !pend_v_q;
        res_ovf_d  = ovf_q;
        res_eor_d  = 1'b1;
        count_d    = '0;
        ovf_d      = 1'b0;
        state_d    = sard_pkg::S_IDLE;
      end

      default: begin
        state_d = sard_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sard_pkg::S_IDLE;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      a_q      <= '0;
      rv_q     <= 1'b0;
      first_q  <= 1'b1;
      seen_q   <= 1'b0;
      pend_v_q <= 1'b0;
      found_q  <= '0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      i_q      <= i_d;
      j_q      <= j_d;
      a_q      <= a_d;
      rv_q     <= rv_d;
      first_q  <= first_d;
      seen_q   <= seen_d;
      pend_v_q <= pend_v_d;
      found_q  <= found_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    prev_q     <= prev_d;
    pend_q     <= pend_d;
    res_val_q  <= res_val_d;
    res_none_q <= res_none_d;
    res_ovf_q  <= res_ovf_d;
    res_eor_q  <= res_eor_d;
  end

  assign result_valid_o = res_v_q;
  assign dup_value_o    = res_val_q;
  assign none_found_o   = res_none_q;
  assign overflow_o     = res_ovf_q;
  assign end_of_run_o   = res_eor_q;

endmodule

// ===== rtl/sort_and_report_duplicates_unit.sv =====
// sort_and_report_duplicates_unit: top level of the duplicate finder
// depends on sard_pkg, sard_store, sard_cmp and sard_ctrl

// Collects a set of signed 32-bit values, one per transaction (start_i high
// while busy_o is low), the final one flagged by last_i. While values are
// being loaded, busy_o stays low throughout. On the last value the
// block raises busy_o, sorts the stored set in place with an insertion sort
// and then walks the sorted set once, reporting every value that occurs at
// least twice, once each and in ascending order, at most 32 per set. Each
// result is shown for exactly one cycle, marked by result_valid_o; the
// receiver cannot hold results off, so it must take every strobe. The final
// result of a set carries end_of_run_o; a set with no repeated value gives
// a single result with none_found_o set and dup_value_o zero. Values beyond
// CAPACITY are dropped and every result of that set carries overflow_o.
// After the last value of a set with n stored values, the sort needs at
// most n(n-1)/2 element shifts; a lone value skips the sort, and the scan
// stops early once 32 repeated values have been found. The final result
// shows in the same cycle in which busy_o falls. The value store, read
// once and written once per cycle under one comparator, sets the pace of
// the sort and the scan.

module sort_and_report_duplicates_unit #(
  parameter int unsigned CAPACITY = sard_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [sard_pkg::VAL_W-1:0] value_i,
  input  logic                              last_i,
  output logic                              result_valid_o,
  output logic signed [sard_pkg::VAL_W-1:0] dup_value_o,
  output logic                              none_found_o,
  output logic                              overflow_o,
  output logic                              end_of_run_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // store port
  logic                              we;
  logic [AW-1:0]                     waddr;
  logic signed [sard_pkg::VAL_W-1:0] wdata;
  logic                              re;
  logic [AW-1:0]                     raddr;
  logic signed [sard_pkg::VAL_W-1:0] rdata;

  // shared comparator: store read data against key (sort) or previous (scan)
  logic signed [sard_pkg::VAL_W-1:0] cmp_b;
  sard_pkg::cmp_res_t                cmp_res;

  sard_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sard_cmp u_cmp (
    .a_i   (rdata),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  // sequencer: load, sort, scan and result register
  sard_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata),
    .cmp_b_o        (cmp_b),
    .cmp_i          (cmp_res),
    .result_valid_o (result_valid_o),
    .dup_value_o    (dup_value_o),
    .none_found_o   (none_found_o),
    .overflow_o     (overflow_o),
    .end_of_run_o   (end_of_run_o)
  );

endmodule

// ===== rtl/sard_checker.sv =====
// sard_checker: port-level assertions for sort_and_report_duplicates_unit
// depends on sard_pkg; bound to the top level below

module sard_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              last_i,
  input logic                              result_valid_o,
  input logic signed [sard_pkg::VAL_W-1:0] dup_value_o,
  input logic                              none_found_o,
  input logic                              end_of_run_o
);

  // a none-found result is the only one of its set and carries zero
  a_none_found_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && none_found_o) |-> (end_of_run_o && (dup_value_o == '0)))
    else $error("none_found result not final or not zero");

  // results ahead of the final one only appear while the set is being worked
  a_mid_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !end_of_run_o) |-> busy_o)
    else $error("intermediate result outside processing");

  // nothing follows the final result straight away
  a_quiet_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && end_of_run_o) |=> !result_valid_o)
    else $error("result right after end of run");

  // a transaction that does not close the set keeps the unit loading
  a_load_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_i) |=> (!busy_o && !result_valid_o))
    else $error("unit left loading on a non-final transaction");

endmodule

bind sort_and_report_duplicates_unit sard_checker u_sard_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .last_i         (last_i),
  .result_valid_o (result_valid_o),
  .dup_value_o    (dup_value_o),
  .none_found_o   (none_found_o),
  .end_of_run_o   (end_of_run_o)
);
